// ----- hdl/voxel_axis_shell_probe_defines.svh -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe: assertion macros
// Concurrent check macros for the file that carries assertions.
// They expect i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VOXEL_AXIS_SHELL_PROBE_DEFINES_SVH
`define VOXEL_AXIS_SHELL_PROBE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define AVSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("avsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AVSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("avsp: next-cycle check failed");

`else

`define AVSP_ASSERT_NOW(lbl, ante, cons)
`define AVSP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/avsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe package
// Grid geometry, direction codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package avsp_pkg;

    localparam int GRID_X = 32;
    localparam int GRID_Y = 32;
    localparam int GRID_Z = 32;

    // Indices are 5 bits wide, so the addressable grid stops at 32.
    localparam int EDGE_X = (GRID_X < 32) ? GRID_X : 32;
    localparam int EDGE_Y = (GRID_Y < 32) ? GRID_Y : 32;
    localparam int EDGE_Z = (GRID_Z < 32) ? GRID_Z : 32;

    localparam int CW     = 5;
    localparam int XW     = $clog2(EDGE_X);
    localparam int ROWS   = EDGE_Y * EDGE_Z;
    localparam int ROW_AW = $clog2(ROWS);

    localparam logic [CW-1:0] TOP_X = CW'(EDGE_X - 1);
    localparam logic [CW-1:0] TOP_Y = CW'(EDGE_Y - 1);
    localparam logic [CW-1:0] TOP_Z = CW'(EDGE_Z - 1);

    localparam logic [4:0] PROBE_DIST_RESET = 5'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] DIR_MX = 3'd0;
    localparam logic [2:0] DIR_PX = 3'd1;
    localparam logic [2:0] DIR_PY = 3'd2;
    localparam logic [2:0] DIR_MY = 3'd3;
    localparam logic [2:0] DIR_MZ = 3'd4;
    localparam logic [2:0] DIR_PZ = 3'd5;

    typedef struct packed {
        logic          is_query;
        logic          in_grid;
        logic          occupied;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [CW-1:0] xm;
        logic [CW-1:0] xp;
        logic [CW-1:0] yp;
        logic [CW-1:0] ym;
        logic [CW-1:0] zm;
        logic [CW-1:0] zp;
    } t_cmd;

endpackage

// ----- hdl/avsp_front.sv -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe: front end
// Accepts items, holds the probe distance and turns each item into a
// command with its grid check and clamped probe coordinates.
// ----------------------------------------------------------------------------
module avsp_front
    import avsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [4:0]    i_cfg_wr_data,
    input  logic          push,
    output logic          full,
    input  logic          i_op,
    input  logic [CW-1:0] i_vx,
    input  logic [CW-1:0] i_vy,
    input  logic [CW-1:0] i_vz,
    input  logic          i_occupied,
    input  logic          i_fifo_full,
    input  logic          i_clearing,
    output logic          o_cmd_push,
    output t_cmd          o_cmd
);

    logic [4:0] r_probe_dist;

    function automatic logic [CW-1:0] step_down(logic [CW-1:0] c, logic [4:0] r);
        logic [CW-1:0] res;
        res = (c >= CW'(r)) ? c - CW'(r) : '0;
        return res;
    endfunction

    function automatic logic [CW-1:0] step_up(logic [CW-1:0] c, logic [4:0] r,
                                              logic [CW-1:0] top);
        logic [CW:0] sum;
        sum = {1'b0, c} + {1'b0, r};
        return (sum > {1'b0, top}) ? top : sum[CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_dist <= PROBE_DIST_RESET;
        end else if (i_cfg_wr_en) begin
            r_probe_dist <= i_cfg_wr_data;
        end
    end

    assign full       = i_fifo_full | i_clearing;
    assign o_cmd_push = push & ~full;

    always_comb begin
        o_cmd.is_query = (i_op == OP_QUERY);
        o_cmd.in_grid  = ({1'b0, i_vx} < (CW+1)'(EDGE_X)) &&
                         ({1'b0, i_vy} < (CW+1)'(EDGE_Y)) &&
                         ({1'b0, i_vz} < (CW+1)'(EDGE_Z));
        o_cmd.occupied = i_occupied;
        o_cmd.x        = i_vx;
        o_cmd.y        = i_vy;
        o_cmd.z        = i_vz;
        o_cmd.xm       = step_down(i_vx, r_probe_dist);
        o_cmd.xp       = step_up(i_vx, r_probe_dist, TOP_X);
        o_cmd.yp       = step_up(i_vy, r_probe_dist, TOP_Y);
        o_cmd.ym       = step_down(i_vy, r_probe_dist);
        o_cmd.zm       = step_down(i_vz, r_probe_dist);
        o_cmd.zp       = step_up(i_vz, r_probe_dist, TOP_Z);
    end

endmodule

// ----- hdl/avsp_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe: command queue
// Two-entry queue that lets the front accept while the back is busy.
// ----------------------------------------------------------------------------
module avsp_cmd_fifo
    import avsp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hdl/avsp_back.sv -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe: back end
// Owns the occupancy bitmap (one row of x bits per y,z pair), clears it
// after reset, applies writes and runs the probe sequence of each query.
// ----------------------------------------------------------------------------
module avsp_back
    import avsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    output logic          o_clearing,
    input  logic          pop,
    output logic          empty,
    output logic          o_found,
    output logic [CW-1:0] o_px,
    output logic [CW-1:0] o_py,
    output logic [CW-1:0] o_pz,
    output logic [2:0]    o_direction,
    output logic          o_last
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Row reads of one query; the center row also serves the two x probes.
    localparam logic [2:0] STEP_C  = 3'd0;
    localparam logic [2:0] STEP_PY = 3'd1;
    localparam logic [2:0] STEP_MY = 3'd2;
    localparam logic [2:0] STEP_MZ = 3'd3;
    localparam logic [2:0] STEP_PZ = 3'd4;

    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    logic [EDGE_X-1:0] r_map [ROWS];
    logic [EDGE_X-1:0] r_rd_data;

    t_state            r_state,    n_state;
    t_cmd              r_cmd,      n_cmd;
    logic [2:0]        r_step,     n_step;
    logic              r_rd_vld,   n_rd_vld;
    logic [2:0]        r_rd_step,  n_rd_step;
    logic              r_center,   n_center;
    logic [5:0]        r_mask,     n_mask;
    logic [ROW_AW-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_vld,  n_out_vld;
    logic              r_found,    n_found;
    logic [CW-1:0]     r_px,       n_px;
    logic [CW-1:0]     r_py,       n_py;
    logic [CW-1:0]     r_pz,       n_pz;
    logic [2:0]        r_dir,      n_dir;
    logic              r_last,     n_last;

    logic              mem_we;
    logic [ROW_AW-1:0] mem_addr;
    logic [EDGE_X-1:0] mem_wbe;
    logic [EDGE_X-1:0] mem_wdata;
    logic              out_take;
    logic [2:0]        pick;

    function automatic logic [ROW_AW-1:0] row_addr(logic [CW-1:0] y, logic [CW-1:0] z);
        logic [15:0] full_addr;
        full_addr = 16'(z) * 16'(EDGE_Y) + 16'(y);
        return full_addr[ROW_AW-1:0];
    endfunction

    function automatic logic [2:0] first_dir(logic [5:0] m);
        logic [2:0] d;
        d = DIR_MX;
        for (int i = 5; i >= 0; i--) begin
            if (m[i]) begin
                d = 3'(i);
            end
        end
        return d;
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int i = 0; i < EDGE_X; i++) begin
                if (mem_wbe[i]) begin
                    r_map[mem_addr][i] <= mem_wdata[i];
                end
            end
        end
        r_rd_data <= r_map[mem_addr];
    end

    assign out_take = ~r_out_vld | pop;
    assign pick     = first_dir(r_mask);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_step     = r_step;
        n_rd_vld   = 1'b0;
        n_rd_step  = r_step;
        n_center   = r_center;
        n_mask     = r_mask;
        n_clr_addr = r_clr_addr;
        n_out_vld  = r_out_vld & ~pop;
        n_found    = r_found;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_dir      = r_dir;
        n_last     = r_last;
        o_cmd_pop  = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_clr_addr;
        mem_wbe    = '1;
        mem_wdata  = '0;

        // A row read issued last cycle returns now; a set bit means occupied.
        if (r_rd_vld) begin
            case (r_rd_step)
                STEP_C: begin
                    n_center         = r_rd_data[r_cmd.x[XW-1:0]];
                    n_mask[DIR_MX]   = ~r_rd_data[r_cmd.xm[XW-1:0]];
                    n_mask[DIR_PX]   = ~r_rd_data[r_cmd.xp[XW-1:0]];
                end
                STEP_PY: n_mask[DIR_PY] = ~r_rd_data[r_cmd.x[XW-1:0]];
                STEP_MY: n_mask[DIR_MY] = ~r_rd_data[r_cmd.x[XW-1:0]];
                STEP_MZ: n_mask[DIR_MZ] = ~r_rd_data[r_cmd.x[XW-1:0]];
                STEP_PZ: n_mask[DIR_PZ] = ~r_rd_data[r_cmd.x[XW-1:0]];
                default: n_mask = r_mask;
            endcase
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == LAST_ROW) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_query) begin
                        mem_we    = i_cmd.in_grid;
                        mem_addr  = row_addr(i_cmd.y, i_cmd.z);
                        mem_wbe   = '0;
                        mem_wbe[i_cmd.x[XW-1:0]] = 1'b1;
                        mem_wdata = {EDGE_X{i_cmd.occupied}};
                    end else begin
                        n_cmd   = i_cmd;
                        n_step  = STEP_C;
                        n_mask  = '0;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                case (r_step)
                    STEP_C:  mem_addr = row_addr(r_cmd.y,  r_cmd.z);
                    STEP_PY: mem_addr = row_addr(r_cmd.yp, r_cmd.z);
                    STEP_MY: mem_addr = row_addr(r_cmd.ym, r_cmd.z);
                    STEP_MZ: mem_addr = row_addr(r_cmd.y,  r_cmd.zm);
                    default: mem_addr = row_addr(r_cmd.y,  r_cmd.zp);
                endcase
                n_rd_vld = 1'b1;
                if (r_step == STEP_PZ) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DRAIN: begin
                // An empty or out-of-grid center yields no probe points.
                if (!(r_cmd.in_grid && r_center)) begin
                    n_mask = '0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_take) begin
                    n_out_vld = 1'b1;
                    if (r_mask == 6'd0) begin
                        n_found = 1'b0;
                        n_px    = '0;
                        n_py    = '0;
                        n_pz    = '0;
                        n_dir   = DIR_MX;
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_found      = 1'b1;
                        n_dir        = pick;
                        n_px         = r_cmd.x;
                        n_py         = r_cmd.y;
                        n_pz         = r_cmd.z;
                        case (pick)
                            DIR_MX:  n_px = r_cmd.xm;
                            DIR_PX:  n_px = r_cmd.xp;
                            DIR_PY:  n_py = r_cmd.yp;
                            DIR_MY:  n_py = r_cmd.ym;
                            DIR_MZ:  n_pz = r_cmd.zm;
                            default: n_pz = r_cmd.zp;
                        endcase
                        n_mask       = r_mask;
                        n_mask[pick] = 1'b0;
                        n_last       = (n_mask == 6'd0);
                        if (n_mask == 6'd0) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_step     <= STEP_C;
            r_rd_vld   <= 1'b0;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
            r_mask     <= '0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_rd_vld   <= n_rd_vld;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
            r_mask     <= n_mask;
        end
        r_cmd     <= n_cmd;
        r_rd_step <= n_rd_step;
        r_center  <= n_center;
        r_found   <= n_found;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
        r_dir     <= n_dir;
        r_last    <= n_last;
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign empty       = ~r_out_vld;
    assign o_found     = r_found;
    assign o_px        = r_px;
    assign o_py        = r_py;
    assign o_pz        = r_pz;
    assign o_direction = r_dir;
    assign o_last      = r_last;

endmodule

// ----- hdl/voxel_axis_shell_probe.sv -----
// ----------------------------------------------------------------------------
// Voxel axis shell probe
// Keeps a 32x32x32 occupancy bitmap and reports the empty axis probe points
// around occupied voxels.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on a queue-style port: a transaction takes place when push is
// high and full is low. A write item (op 0) sets or clears one voxel; a query
// item (op 1) produces one or more results on the output port, where a
// transaction takes place when pop is high and empty is low. The last result
// of a query has o_last set; a query with no empty probe point gives a single
// result with o_found low.
// The back end applies a write as it takes it from the queue. A query runs
// through its steps in order: it is taken from the queue, five row reads go
// to the single-port bitmap memory, the last read returns, and then its 1 to
// 6 results are emitted. A two-entry command queue lets the input side keep
// accepting while a query runs.
// After reset the bitmap is cleared one row per cycle with full held high;
// the probe distance resets to 3 and may be written at any time the block is
// idle. When the receiver stalls, the held result stays on the output ports
// and the back end waits; the input stalls once the queue fills.
// ----------------------------------------------------------------------------
`include "voxel_axis_shell_probe_defines.svh"

module voxel_axis_shell_probe
    import avsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [4:0]    i_cfg_wr_data,
    input  logic          push,
    output logic          full,
    input  logic          i_op,
    input  logic [CW-1:0] i_vx,
    input  logic [CW-1:0] i_vy,
    input  logic [CW-1:0] i_vz,
    input  logic          i_occupied,
    input  logic          pop,
    output logic          empty,
    output logic          o_found,
    output logic [CW-1:0] o_px,
    output logic [CW-1:0] o_py,
    output logic [CW-1:0] o_pz,
    output logic [2:0]    o_direction,
    output logic          o_last
);

    logic fifo_full;
    logic clearing;
    logic cmd_push;
    t_cmd front_cmd;
    logic cmd_valid;
    t_cmd back_cmd;
    logic cmd_pop;

    avsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_vx          (i_vx),
        .i_vy          (i_vy),
        .i_vz          (i_vz),
        .i_occupied    (i_occupied),
        .i_fifo_full   (fifo_full),
        .i_clearing    (clearing),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    avsp_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .o_cmd   (back_cmd),
        .i_pop   (cmd_pop)
    );

    avsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .pop         (pop),
        .empty       (empty),
        .o_found     (o_found),
        .o_px        (o_px),
        .o_py        (o_py),
        .o_pz        (o_pz),
        .o_direction (o_direction),
        .o_last      (o_last)
    );

    `AVSP_ASSERT_NOW(a_clear_blocks_input, clearing, full)
    `AVSP_ASSERT_NOW(a_no_cmd_during_clear, clearing, !cmd_pop)
    `AVSP_ASSERT_NOW(a_miss_is_last, !empty && !o_found, o_last)
    `AVSP_ASSERT_NOW(a_direction_range, !empty && o_found, o_direction <= DIR_PZ)

endmodule

// ----- dv/voxel_axis_shell_probe_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel axis shell probe testbench
// Drives write and query items into the occupancy bitmap, predicts the empty
// axis probe points of every query, and checks each result transaction in
// order. A directed table comes first, then random segments under several
// probe distances and idle patterns, two of them with a long receiver stall.
// ----------------------------------------------------------------------------
module voxel_axis_shell_probe_tb
    import avsp_pkg::*;
();

    localparam int SEG_COUNT     = 6;
    localparam int SEG_ITEMS     = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAP_SIZE      = EDGE_X * EDGE_Y * EDGE_Z;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic [2:0]    dir;
        logic          last;
    } t_probe_res;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          occ;
        logic          typed;
    } t_stim_row;

    localparam t_probe_res NO_PROBE = '{found: 1'b0, px: '0, py: '0, pz: '0,
                                        dir: '0, last: 1'b1};

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_wr_en   = 1'b0;
    logic [4:0]    i_cfg_wr_data = '0;
    logic          push          = 1'b0;
    logic          full;
    logic          i_op          = OP_WRITE;
    logic [CW-1:0] i_vx          = '0;
    logic [CW-1:0] i_vy          = '0;
    logic [CW-1:0] i_vz          = '0;
    logic          i_occupied    = 1'b0;
    logic          pop           = 1'b0;
    logic          empty;
    logic          o_found;
    logic [CW-1:0] o_px;
    logic [CW-1:0] o_py;
    logic [CW-1:0] o_pz;
    logic [2:0]    o_direction;
    logic          o_last;

    voxel_axis_shell_probe i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_vx          (i_vx),
        .i_vy          (i_vy),
        .i_vz          (i_vz),
        .i_occupied    (i_occupied),
        .pop           (pop),
        .empty         (empty),
        .o_found       (o_found),
        .o_px          (o_px),
        .o_py          (o_py),
        .o_pz          (o_pz),
        .o_direction   (o_direction),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the bitmap and the probe distance register.
    bit         occ_map [MAP_SIZE];
    logic [4:0] probe_dist = PROBE_DIST_RESET;

    t_probe_res probe_q [$];
    int         err_cnt = 0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_cnt   = 0;

    logic [CW-1:0] hot_x [16];
    logic [CW-1:0] hot_y [16];
    logic [CW-1:0] hot_z [16];
    int            hot_n  = 0;
    int            hot_wr = 0;

    t_stim_row directed_rows [21] = '{
        '{OP_QUERY, 5'd0,  5'd0,  5'd0,  1'b1, 1'b1},
        '{OP_QUERY, 5'd31, 5'd31, 5'd31, 1'b0, 1'b1},
        '{OP_WRITE, 5'd0,  5'd0,  5'd0,  1'b1, 1'b0},
        '{OP_QUERY, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0},
        '{OP_WRITE, 5'd31, 5'd31, 5'd31, 1'b1, 1'b0},
        '{OP_QUERY, 5'd31, 5'd31, 5'd31, 1'b1, 1'b0},
        '{OP_WRITE, 5'd16, 5'd16, 5'd16, 1'b1, 1'b0},
        '{OP_QUERY, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0},
        '{OP_WRITE, 5'd13, 5'd16, 5'd16, 1'b1, 1'b0},
        '{OP_WRITE, 5'd16, 5'd16, 5'd19, 1'b1, 1'b0},
        '{OP_QUERY, 5'd16, 5'd16, 5'd16, 1'b0, 1'b0},
        '{OP_WRITE, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0},
        '{OP_QUERY, 5'd0,  5'd0,  5'd0,  1'b0, 1'b1},
        '{OP_WRITE, 5'd5,  5'd5,  5'd5,  1'b1, 1'b0},
        '{OP_WRITE, 5'd2,  5'd5,  5'd5,  1'b1, 1'b0},
        '{OP_WRITE, 5'd8,  5'd5,  5'd5,  1'b1, 1'b0},
        '{OP_WRITE, 5'd5,  5'd8,  5'd5,  1'b1, 1'b0},
        '{OP_WRITE, 5'd5,  5'd2,  5'd5,  1'b1, 1'b0},
        '{OP_WRITE, 5'd5,  5'd5,  5'd2,  1'b1, 1'b0},
        '{OP_WRITE, 5'd5,  5'd5,  5'd8,  1'b1, 1'b0},
        '{OP_QUERY, 5'd5,  5'd5,  5'd5,  1'b0, 1'b1}
    };

    function automatic bit voxel_set(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        if (x >= EDGE_X || y >= EDGE_Y || z >= EDGE_Z) begin
            return 1'b0;
        end
        return occ_map[(int'(z) * EDGE_Y + int'(y)) * EDGE_X + int'(x)];
    endfunction

    function automatic logic [CW-1:0] coord_down(logic [CW-1:0] c);
        return (c >= probe_dist) ? c - probe_dist : '0;
    endfunction

    function automatic logic [CW-1:0] coord_up(logic [CW-1:0] c, logic [CW-1:0] top);
        int sum;
        sum = int'(c) + int'(probe_dist);
        return (sum > int'(top)) ? top : CW'(sum);
    endfunction

    task automatic store_voxel(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic v);
        if (x < EDGE_X && y < EDGE_Y && z < EDGE_Z) begin
            occ_map[(int'(z) * EDGE_Y + int'(y)) * EDGE_X + int'(x)] = v;
        end
    endtask

    // Empty probe points around an occupied voxel, in the fixed axis order.
    task automatic predict_probes(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        logic [2:0]    dir_order [6];
        t_probe_res    hits [6];
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic [CW-1:0] qz;
        int            n;
        dir_order = '{DIR_MX, DIR_PX, DIR_PY, DIR_MY, DIR_MZ, DIR_PZ};
        n = 0;
        if (voxel_set(x, y, z)) begin
            for (int d = 0; d < 6; d++) begin
                qx = x;
                qy = y;
                qz = z;
                case (dir_order[d])
                    DIR_MX: qx = coord_down(x);
                    DIR_PX: qx = coord_up(x, TOP_X);
                    DIR_PY: qy = coord_up(y, TOP_Y);
                    DIR_MY: qy = coord_down(y);
                    DIR_MZ: qz = coord_down(z);
                    default: qz = coord_up(z, TOP_Z);
                endcase
                if (!voxel_set(qx, qy, qz)) begin
                    hits[n] = '{found: 1'b1, px: qx, py: qy, pz: qz,
                                dir: dir_order[d], last: 1'b0};
                    n++;
                end
            end
        end
        if (n == 0) begin
            probe_q.push_back(NO_PROBE);
        end else begin
            hits[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) begin
                probe_q.push_back(hits[i]);
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // One input transaction; typed rows carry the plain not-found result.
    task automatic send_item(logic op, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z, logic occ, logic typed);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_op       <= op;
        i_vx       <= x;
        i_vy       <= y;
        i_vz       <= z;
        i_occupied <= occ;
        do @(posedge i_clk); while (full);
        if (op == OP_WRITE) begin
            store_voxel(x, y, z, occ);
        end else if (typed) begin
            probe_q.push_back(NO_PROBE);
        end else begin
            predict_probes(x, y, z);
        end
    endtask

    function automatic logic [CW-1:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) begin
            case ($urandom_range(0, 3))
                0: return 5'd0;
                1: return 5'd1;
                2: return 5'd30;
                default: return 5'd31;
            endcase
        end else if (k < 6) begin
            return CW'($urandom_range(12, 19));
        end
        return CW'($urandom_range(0, 31));
    endfunction

    // Queries mostly land on recently set voxels so that probes are exercised.
    task automatic random_item();
        logic          op;
        logic          occ;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        int            k;
        op  = ($urandom_range(0, 1) == 1) ? OP_QUERY : OP_WRITE;
        occ = ($urandom_range(0, 9) < 7);
        if (op == OP_QUERY && hot_n > 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, hot_n - 1);
            x = hot_x[k];
            y = hot_y[k];
            z = hot_z[k];
        end else begin
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
        end
        if (op == OP_WRITE && occ) begin
            hot_x[hot_wr] = x;
            hot_y[hot_wr] = y;
            hot_z[hot_wr] = z;
            hot_wr = (hot_wr + 1) % 16;
            if (hot_n < 16) begin
                hot_n++;
            end
        end
        send_item(op, x, y, z, occ, 1'b0);
    endtask

    // A write item leaves no result behind, so give the back end time to retire it.
    task automatic wait_drained();
        push <= 1'b0;
        while (probe_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_probe_dist(logic [4:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        probe_dist = value;
    endtask

    // Receiver: random pops, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_probe_res want;
        if (i_rst_n && pop && !empty) begin
            if (probe_q.size() == 0) begin
                report_mismatch("result with nothing expected, found", o_found, 0);
            end else begin
                want = probe_q.pop_front();
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_px !== want.px) report_mismatch("px", o_px, want.px);
                if (o_py !== want.py) report_mismatch("py", o_py, want.py);
                if (o_pz !== want.pz) report_mismatch("pz", o_pz, want.pz);
                if (o_direction !== want.dir) report_mismatch("direction", o_direction, want.dir);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    // The limit covers the bitmap clear after reset and the long hold-off.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("voxel_axis_shell_probe test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [4:0] seg_dist [SEG_COUNT];
        seg_dist = '{5'd1, 5'd31, 5'd0, CW'($urandom_range(2, 30)), 5'd7, 5'd3};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table with the reset probe distance.
        tx_idle_pct <= 25;
        rx_idle_pct <= 45;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].z, directed_rows[i].occ, directed_rows[i].typed);
        end

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            wait_drained();
            write_probe_dist(seg_dist[seg]);
            case (seg / 2)
                0: begin
                    tx_idle_pct <= 25;
                    rx_idle_pct <= 45;
                end
                1: begin
                    tx_idle_pct <= 45;
                    rx_idle_pct <= 25;
                end
                default: begin
                    tx_idle_pct <= 0;
                    rx_idle_pct <= 0;
                end
            endcase
            // Stall the receiver while items keep coming so the input backs up.
            if (seg == 0 || seg == 4) begin
                hold_req <= hold_req + 1;
            end
            repeat (SEG_ITEMS) random_item();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("voxel_axis_shell_probe test passed");
        end else begin
            $display("voxel_axis_shell_probe test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/avsp_pkg.sv
hdl/avsp_front.sv
hdl/avsp_cmd_fifo.sv
hdl/avsp_back.sv
hdl/voxel_axis_shell_probe.sv
dv/voxel_axis_shell_probe_tb.sv
